// ----- src/mmp_pkg.sv -----
// Types and constants shared by the MIDI message parser modules.
package mmp_pkg;

   localparam logic [7:0] RealtimeFirst = 8'hF8;
   localparam logic [7:0] SysexStart    = 8'hF0;
   localparam logic [7:0] SysexEnd      = 8'hF7;
   localparam logic [7:0] OneByteFirst  = 8'hF4;
   localparam logic [7:0] TimeCode      = 8'hF1;
   localparam logic [7:0] SongPosition  = 8'hF2;
   localparam logic [7:0] SongSelect    = 8'hF3;
   localparam logic [7:0] NoStatus      = 8'h00;
   localparam logic [4:0] OmniChannel   = 5'd0;
   localparam logic [4:0] LastChannel   = 5'd16;

   localparam logic [3:0] NibNoteOff    = 4'h8;
   localparam logic [3:0] NibNoteOn     = 4'h9;
   localparam logic [3:0] NibPolyPress  = 4'hA;
   localparam logic [3:0] NibControl    = 4'hB;
   localparam logic [3:0] NibProgram    = 4'hC;
   localparam logic [3:0] NibChanPress  = 4'hD;
   localparam logic [3:0] NibPitchBend  = 4'hE;
   localparam logic [3:0] NibSystem     = 4'hF;

   localparam logic [1:0] LenOne        = 2'd1;
   localparam logic [1:0] LenTwo        = 2'd2;
   localparam logic [1:0] LenThree      = 2'd3;

   typedef struct packed {
      logic [7:0] current_status;
      logic       awaiting_second_data;
      logic       in_sysex;
      logic [6:0] held_first_data;
   } parse_state_type;

   typedef struct packed {
      logic [7:0] status_byte;
      logic [6:0] first_data;
      logic [6:0] second_data;
      logic [1:0] msg_length;
   } message_type;

   localparam parse_state_type StateReset = '{
      current_status:       NoStatus,
      awaiting_second_data: 1'b0,
      in_sysex:             1'b0,
      held_first_data:      7'd0
   };

endpackage

// ----- src/mmp_channels.sv -----
// Handshake channel interfaces for received bytes and parsed messages.
interface mmp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface mmp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] status_byte;
   logic [6:0] first_data;
   logic [6:0] second_data;
   logic [1:0] msg_length;

   modport source (output valid, output status_byte, output first_data,
                   output second_data, output msg_length, input ready);
   modport sink (input valid, input status_byte, input first_data,
                 input second_data, input msg_length, output ready);
endinterface

// ----- src/mmp_decode.sv -----
// Combinational decode of one MIDI byte against the parser state.
module mmp_decode (
   input  logic [7:0]               rx_byte,
   input  logic [4:0]               listen_channel,
   input  mmp_pkg::parse_state_type state_cur,
   output mmp_pkg::parse_state_type state_nxt,
   output logic                     emit,
   output mmp_pkg::message_type     msg
);
   import mmp_pkg::*;

   logic [7:0] st;
   logic [4:0] chan_plus_one;
   logic       filtered;

   assign st            = state_cur.current_status;
   assign chan_plus_one = {1'b0, st[3:0]} + 5'd1;
   assign filtered      = (st < SysexStart) && (listen_channel != OmniChannel) &&
                          ((listen_channel > LastChannel) || (chan_plus_one != listen_channel));

   always_comb begin
      state_nxt = state_cur;
      emit      = 1'b0;
      msg       = '{status_byte: rx_byte, first_data: 7'd0, second_data: 7'd0,
                    msg_length: LenOne};
      priority if (rx_byte >= RealtimeFirst) begin
         emit = 1'b1;
      end else if (state_cur.in_sysex) begin
         if (rx_byte == SysexEnd) begin
            state_nxt.in_sysex = 1'b0;
         end
      end else if (rx_byte[7]) begin
         state_nxt.awaiting_second_data = 1'b0;
         priority if (rx_byte == SysexStart) begin
            state_nxt.current_status = NoStatus;
            state_nxt.in_sysex       = 1'b1;
         end else if (rx_byte >= OneByteFirst) begin
            state_nxt.current_status = NoStatus;
            emit                     = 1'b1;
         end else begin
            state_nxt.current_status = rx_byte;
         end
      end else if (st == NoStatus || filtered) begin
         state_nxt = state_cur;
      end else if (state_cur.awaiting_second_data) begin
         state_nxt.awaiting_second_data = 1'b0;
         if (st == SongPosition) begin
            state_nxt.current_status = NoStatus;
         end
         emit = 1'b1;
         msg  = '{status_byte: st, first_data: state_cur.held_first_data,
                  second_data: rx_byte[6:0], msg_length: LenThree};
      end else begin
         unique case (st[7:4])
            NibNoteOff, NibNoteOn, NibPolyPress, NibControl, NibPitchBend: begin
               state_nxt.held_first_data      = rx_byte[6:0];
               state_nxt.awaiting_second_data = 1'b1;
            end
            NibProgram, NibChanPress: begin
               emit = 1'b1;
               msg  = '{status_byte: st, first_data: rx_byte[6:0], second_data: 7'd0,
                        msg_length: LenTwo};
            end
            NibSystem: begin
               priority if (st == SongPosition) begin
                  state_nxt.held_first_data      = rx_byte[6:0];
                  state_nxt.awaiting_second_data = 1'b1;
               end else if (st == TimeCode || st == SongSelect) begin
                  state_nxt.current_status = NoStatus;
                  emit = 1'b1;
                  msg  = '{status_byte: st, first_data: rx_byte[6:0], second_data: 7'd0,
                           msg_length: LenTwo};
               end else begin
                  state_nxt.current_status = NoStatus;
               end
            end
            default: begin
               state_nxt.current_status = NoStatus;
            end
         endcase
      end
   end

endmodule

// ----- src/midi_message_parser.sv -----
// Top level of the MIDI byte-stream parser with running status.
//
// The req_ch channel takes one raw received MIDI byte per item. The rsp_ch
// channel gives one item per completed message: status byte, up to two data
// bytes and the message length. Real-time bytes come out as one-byte messages
// without disturbing a message in progress, and system exclusive data is
// skipped until its end byte. The csr port sets the listen channel, where
// zero accepts every channel; write it only while the block is idle.
//
// Each byte is decoded combinationally against the parser state, and a
// message it completes appears in the output register in the following
// cycle. One byte is accepted every cycle while the receiver takes results.
// When a result waits and rsp_ch.ready is low, req_ch.ready drops until
// that result is taken; nothing is dropped or repeated.
//
// Reset clears running status, the sysex flag, the pending data byte, the
// listen channel and the output valid flag. The block is ready on the first
// cycle after reset.
module midi_message_parser (
   input  logic       clock,
   input  logic       reset,
   mmp_req_if.sink    req_ch,
   mmp_rsp_if.source  rsp_ch,
   input  logic       csr_we,
   input  logic [4:0] csr_wdata
);
   import mmp_pkg::*;

   parse_state_type state_ff;
   parse_state_type state_in;
   parse_state_type state_nxt;
   message_type     msg_ff;
   message_type     msg_in;
   message_type     dec_msg;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic [4:0]      listen_ff;
   logic [4:0]      listen_in;
   logic            dec_emit;
   logic            accept;

   mmp_decode u_decode (
      .rx_byte        (req_ch.rx_byte),
      .listen_channel (listen_ff),
      .state_cur      (state_ff),
      .state_nxt      (state_nxt),
      .emit           (dec_emit),
      .msg            (dec_msg)
   );

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign state_in     = accept ? state_nxt : state_ff;
   assign msg_in       = (accept && dec_emit) ? dec_msg : msg_ff;
   assign rsp_valid_in = accept ? dec_emit : (rsp_valid_ff && !rsp_ch.ready);
   assign listen_in    = csr_we ? csr_wdata : listen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StateReset;
         rsp_valid_ff <= 1'b0;
         listen_ff    <= OmniChannel;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         listen_ff    <= listen_in;
      end
   end

   always_ff @(posedge clock) begin
      msg_ff <= msg_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status_byte = msg_ff.status_byte;
   assign rsp_ch.first_data  = msg_ff.first_data;
   assign rsp_ch.second_data = msg_ff.second_data;
   assign rsp_ch.msg_length  = msg_ff.msg_length;

   a_pending_has_status: assert property (@(posedge clock) disable iff (reset)
      state_ff.awaiting_second_data |-> (state_ff.current_status != NoStatus))
      else $error("pending data byte without running status");

   a_sysex_clears_status: assert property (@(posedge clock) disable iff (reset)
      state_ff.in_sysex |-> (state_ff.current_status == NoStatus &&
                             !state_ff.awaiting_second_data))
      else $error("sysex entered with running status left set");

   a_result_is_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (msg_ff.status_byte[7] && msg_ff.msg_length != 2'd0))
      else $error("result without a status byte or length");

   a_one_byte_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && msg_ff.msg_length == LenOne) |->
         (msg_ff.first_data == 7'd0 && msg_ff.second_data == 7'd0))
      else $error("one-byte message carries data");

endmodule

// ----- dv/midi_message_parser_tb.sv -----
// Self-checking testbench for the MIDI message parser with a built-in parse predictor.
module midi_message_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mmp_pkg::*;

   localparam int ResetCycles    = 12;
   localparam int CfgSettle      = 3;
   localparam int HoldCycles     = 100;
   localparam int WatchdogLimit  = 2000;
   localparam int DrainCycles    = 4;
   localparam int RandomItems    = 520;
   localparam int FilterItems    = 30;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [4:0] csr_wdata;

   mmp_req_if req_ch ();
   mmp_rsp_if rsp_ch ();

   midi_message_parser DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   parse_state_type parse_now = StateReset;
   logic [4:0] listen_chan = OmniChannel;
   message_type pending_msgs[$];

   bit req_gaps_on = 1'b1;
   logic rsp_stall_on = 1'b1;
   logic rsp_hold = 1'b0;
   int rsp_wait = 0;
   int stall_cycles = 0;
   int error_count = 0;
   int bytes_sent = 0;
   int effective_items = 0;
   int messages_checked = 0;
   event hold_go;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      error_count++;
   endtask

   // Advances the parse state by one byte; returns whether the byte mattered.
   function automatic bit parse_byte(input logic [7:0] b);
      parse_state_type prior;
      message_type msg;
      bit has_msg;
      bit chan_ok;
      logic [7:0] st;
      prior = parse_now;
      st = parse_now.current_status;
      has_msg = 1'b0;
      msg = '0;
      chan_ok = st[7:4] == NibSystem || listen_chan == OmniChannel ||
                (listen_chan <= LastChannel && {1'b0, st[3:0]} == listen_chan - 5'd1);
      if (b >= RealtimeFirst) begin
         has_msg = 1'b1;
         msg = '{b, 7'd0, 7'd0, LenOne};
      end else if (parse_now.in_sysex) begin
         if (b == SysexEnd) parse_now.in_sysex = 1'b0;
      end else if (b[7]) begin
         parse_now.awaiting_second_data = 1'b0;
         if (b == SysexStart) begin
            parse_now.current_status = NoStatus;
            parse_now.in_sysex = 1'b1;
         end else if (b >= OneByteFirst) begin
            parse_now.current_status = NoStatus;
            has_msg = 1'b1;
            msg = '{b, 7'd0, 7'd0, LenOne};
         end else begin
            parse_now.current_status = b;
         end
      end else if (st != NoStatus && chan_ok) begin
         if (parse_now.awaiting_second_data) begin
            parse_now.awaiting_second_data = 1'b0;
            if (st == SongPosition) parse_now.current_status = NoStatus;
            has_msg = 1'b1;
            msg = '{st, parse_now.held_first_data, b[6:0], LenThree};
         end else if (st[7:4] == NibProgram || st[7:4] == NibChanPress) begin
            has_msg = 1'b1;
            msg = '{st, b[6:0], 7'd0, LenTwo};
         end else if (st[7:4] != NibSystem || st == SongPosition) begin
            parse_now.held_first_data = b[6:0];
            parse_now.awaiting_second_data = 1'b1;
         end else if (st == TimeCode || st == SongSelect) begin
            parse_now.current_status = NoStatus;
            has_msg = 1'b1;
            msg = '{st, b[6:0], 7'd0, LenTwo};
         end else begin
            parse_now.current_status = NoStatus;
         end
      end
      if (has_msg) pending_msgs.push_back(msg);
      return has_msg || (parse_now != prior);
   endfunction

   task automatic send_byte(input logic [7:0] value);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.rx_byte <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      bytes_sent++;
      if (parse_byte(value)) effective_items++;
   endtask

   task automatic set_listen(input logic [4:0] chan);
      req_ch.valid <= 1'b0;
      while (pending_msgs.size() != 0) @(posedge clock);
      repeat (CfgSettle) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= chan;
      @(posedge clock);
      csr_we <= 1'b0;
      listen_chan = chan;
   endtask

   function automatic logic [7:0] rand_data();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'h7F;
         default: return 8'($urandom_range(0, 127));
      endcase
   endfunction

   task automatic maybe_realtime();
      if ($urandom_range(0, 11) == 0) send_byte(8'($urandom_range(RealtimeFirst, 8'hFF)));
   endtask

   task automatic send_random_phrase();
      int kind;
      int n;
      logic [3:0] nib;
      logic [3:0] chan;
      logic [7:0] st;
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
         nib = 4'($urandom_range(NibNoteOff, NibPitchBend));
         chan = 4'($urandom_range(0, 15));
         if (listen_chan != OmniChannel && listen_chan <= LastChannel &&
             $urandom_range(0, 2) != 0) begin
            chan = 4'(listen_chan - 5'd1);
         end
         st = {nib, chan};
         if (st != parse_now.current_status || $urandom_range(0, 3) == 0) send_byte(st);
         n = $urandom_range(1, 3);
         repeat (n) begin
            send_byte(rand_data());
            maybe_realtime();
            if (nib != NibProgram && nib != NibChanPress && $urandom_range(0, 9) != 0) begin
               send_byte(rand_data());
            end
         end
      end else if (kind < 65) begin
         case ($urandom_range(0, 2))
            0: st = TimeCode;
            1: st = SongPosition;
            default: st = SongSelect;
         endcase
         send_byte(st);
         maybe_realtime();
         send_byte(rand_data());
         if (st == SongPosition) send_byte(rand_data());
         if ($urandom_range(0, 4) == 0) send_byte(rand_data());
      end else if (kind < 73) begin
         send_byte(SysexStart);
         n = $urandom_range(0, 6);
         repeat (n) send_byte(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 7) != 0) send_byte(SysexEnd);
      end else if (kind < 80) begin
         send_byte(8'($urandom_range(OneByteFirst, 8'hFF)));
      end else begin
         send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_directed_messages();
      logic [7:0] seq[$];
      seq = '{8'h45,
              {NibNoteOn, 4'hA}, 8'h00, RealtimeFirst, 8'h7F, 8'h11,
              {NibControl, 4'h1}, 8'h05, 8'h06,
              {NibPitchBend, 4'h0}, 8'h7F, 8'h00,
              {NibProgram, 4'h0}, 8'h7F,
              {NibChanPress, 4'hF}, 8'h00,
              {NibPolyPress, 4'h4}, 8'h01, 8'h02,
              SongPosition, 8'h11, 8'h22, 8'h33,
              TimeCode, 8'h40, SongSelect, 8'h00,
              SysexStart, {NibNoteOff, 4'h5}, 8'hFF, SysexEnd,
              OneByteFirst, 8'hFE};
      foreach (seq[i]) send_byte(seq[i]);
   endtask

   task automatic test_channel_filter();
      logic [4:0] settings[$];
      int goal;
      settings = '{5'd1, LastChannel, 5'd17, 5'd31, 5'($urandom_range(2, 15))};
      foreach (settings[i]) begin
         set_listen(settings[i]);
         goal = bytes_sent + FilterItems;
         while (bytes_sent < goal) send_random_phrase();
      end
      set_listen(OmniChannel);
   endtask

   task automatic test_random_stream();
      int goal;
      goal = bytes_sent + RandomItems;
      while (bytes_sent < goal) begin
         if ($urandom_range(0, 39) == 0) begin
            req_gaps_on = 1'($urandom_range(0, 1));
            rsp_stall_on <= 1'($urandom_range(0, 1));
         end
         if ($urandom_range(0, 149) == 0) begin
            set_listen($urandom_range(0, 1) ? OmniChannel : 5'($urandom_range(1, 16)));
         end
         send_random_phrase();
      end
      req_gaps_on = 1'b1;
      rsp_stall_on <= 1'b1;
   endtask

   task automatic test_backpressure();
      int k;
      set_listen(OmniChannel);
      req_gaps_on = 1'b0;
      rsp_stall_on <= 1'b0;
      -> hold_go;
      send_byte({NibProgram, 4'h3});
      for (k = 0; k < 40; k++) begin
         if (k % 3 == 0) send_byte(8'($urandom_range(RealtimeFirst, 8'hFF)));
         else send_byte(rand_data());
      end
      req_gaps_on = 1'b1;
      rsp_stall_on <= 1'b1;
   endtask

   always begin
      @(hold_go);
      rsp_hold <= 1'b1;
      repeat (HoldCycles) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin : result_check
      message_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            messages_checked++;
            if (pending_msgs.size() == 0) begin
               report_mismatch("item with nothing expected, status_byte",
                               rsp_ch.status_byte, 0);
            end else begin
               want = pending_msgs.pop_front();
               if (rsp_ch.status_byte !== want.status_byte)
                  report_mismatch("status_byte", rsp_ch.status_byte, want.status_byte);
               if (rsp_ch.first_data !== want.first_data)
                  report_mismatch("first_data", rsp_ch.first_data, want.first_data);
               if (rsp_ch.second_data !== want.second_data)
                  report_mismatch("second_data", rsp_ch.second_data, want.second_data);
               if (rsp_ch.msg_length !== want.msg_length)
                  report_mismatch("msg_length", rsp_ch.msg_length, want.msg_length);
            end
            rsp_wait = rsp_stall_on ? $urandom_range(0, 6) : 0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_ch.ready <= (rsp_wait == 0) && !rsp_hold;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WatchdogLimit) begin
         $display("[%0t] no item moved for %0d cycles", $realtime, stall_cycles);
         $display("Regression FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.rx_byte = '0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_messages();
      test_channel_filter();
      test_random_stream();
      test_backpressure();

      req_ch.valid <= 1'b0;
      while (pending_msgs.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      $display("Sent %0d bytes (%0d that changed state or gave a message), checked %0d messages.",
               bytes_sent, effective_items, messages_checked);
      $display("%s%s", "Traffic: channel, system common, sysex, real-time and noise bytes; listen ",
               "channels 0, 1, 16, 17, 31 and random; one long output stall.");
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
